// ===== design/bsrd_pkg.sv =====
package bsrd_pkg;

	localparam int MAX_COLUMNS      = 4096;
	localparam int PIX_PER_REC      = 12;
	localparam int BLANK_ZERO_COUNT = 4096;
	localparam int POS_W            = 13;
	localparam int FIELD_W          = 12;
	localparam int COUNT_W          = 32;
	localparam int S_TDATA_W        = 32;
	localparam int M_TDATA_W        = 104;

	localparam logic OP_DECODE = 1'b0;
	localparam logic OP_READ   = 1'b1;

	localparam logic REG_CAMERA   = 1'b0;
	localparam logic REG_CAPACITY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_FINISH
	} state_t;

endpackage

// ===== design/bsrd_ram.sv =====
module bsrd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== design/binary_scanline_record_decoder_unit.sv =====
// A dropped record goes straight back to idle; a counter read or a blank record goes to the finish state.
// A raw record scans each written pixel and, for each set pixel, does a read-modify-write of its column
// counter in the single-port RAM, a read in the scan state and then a write in the write state.
// One item is in work at a time; a finished result waits in the output register.
// After reset the counter RAM is cleared one entry per cycle, over all MAX_COLUMNS entries, while
// no item is taken; configuration writes are taken at all times.
module binary_scanline_record_decoder_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [bsrd_pkg::POS_W-1:0]        cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// camera_num[1:0], flow_flag[2], pixel_bits[14:3], column_index[26:15], zero[31:27]
	input  logic [bsrd_pkg::S_TDATA_W-1:0]    s_tdata,
	// operation[0], raw_flag[1]
	input  logic [1:0]                        s_tuser,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// column_start[11:0], segment_length[24:12], pixel_mask[36:25], line_length[49:37],
	// pixels_in_row[62:50], line_flow[63], line_overflow[64], count_value[96:65], zero[103:97]
	output logic [bsrd_pkg::M_TDATA_W-1:0]    m_tdata,
	// segment_is_blank[0]
	output logic                              m_tuser,
	output logic                              m_tlast
);

	import bsrd_pkg::*;

	localparam int AW = $clog2(MAX_COLUMNS);

	state_t state_q, state_d;

	logic [1:0]         cam_sel_q;
	logic [POS_W-1:0]   cap_q;
	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   rowcnt_q;
	logic               ovf_q;
	logic [AW-1:0]      clr_addr_q;
	logic [3:0]         idx_q;
	logic [FIELD_W-1:0] sh_q;

	logic               op_q;
	logic               eol_q;
	logic               flow_q;
	logic               in_range_q;
	logic [POS_W-1:0]   seg_len_q;
	logic [FIELD_W-1:0] seg_mask_q;
	logic               seg_blank_q;

	logic               m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic               m_tuser_q;
	logic               m_tlast_q;

	logic               in_op, in_raw, in_eol, in_flow;
	logic [1:0]         in_cam;
	logic [FIELD_W-1:0] in_bits, in_col;
	logic               in_col_ok;

	logic [POS_W-1:0]   cap_eff, space, raw_len, blank_len, seg_len_d;
	logic [FIELD_W-1:0] raw_mask;
	logic               blank_ovf;
	logic               accept, take_rec, scan_done, step, out_free, finish_go;

	logic [POS_W-1:0]   new_pos, line_len;
	logic [FIELD_W-1:0] col_start;
	logic [COUNT_W-1:0] count_val;
	logic [M_TDATA_W-1:0] res_data;

	logic               ram_en, ram_we;
	logic [AW-1:0]      ram_addr, pix_addr;
	logic [COUNT_W-1:0] ram_wdata, ram_rdata;

	assign in_op   = s_tuser[0];
	assign in_raw  = s_tuser[1];
	assign in_eol  = s_tlast;
	assign in_cam  = s_tdata[1:0];
	assign in_flow = s_tdata[2];
	assign in_bits = s_tdata[14:3];
	assign in_col  = s_tdata[26:15];
	assign in_col_ok = {20'd0, in_col} < 32'(MAX_COLUMNS);

	assign cap_eff   = ({19'd0, cap_q} > 32'(MAX_COLUMNS)) ? POS_W'(MAX_COLUMNS) : cap_q;
	assign space     = (pos_q < cap_eff) ? cap_eff - pos_q : '0;
	assign raw_len   = (space < POS_W'(PIX_PER_REC)) ? space : POS_W'(PIX_PER_REC);
	assign raw_mask  = in_bits & (12'hFFF << (4'(PIX_PER_REC) - raw_len[3:0]));
	assign blank_len = (in_bits == '0) ? POS_W'(BLANK_ZERO_COUNT) : {1'b0, in_bits};
	assign blank_ovf = blank_len > space;
	assign seg_len_d = in_raw ? raw_len : (blank_ovf ? '0 : blank_len);

	assign accept    = s_tvalid && s_tready;
	assign take_rec  = accept && (in_op == OP_DECODE) && (in_cam == cam_sel_q);
	assign scan_done = {9'd0, idx_q} == seg_len_q;
	assign step      = (state_q == ST_WRITE)
		|| ((state_q == ST_SCAN) && !scan_done && !sh_q[FIELD_W-1]);
	assign out_free  = !m_tvalid_q || m_tready;
	assign finish_go = (state_q == ST_FINISH) && out_free;
	assign pix_addr  = AW'(pos_q) + AW'(idx_q);

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = pix_addr;
		ram_wdata = ram_rdata + 32'd1;
		case (state_q)
			ST_CLEAR: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = clr_addr_q;
				ram_wdata = '0;
				if (clr_addr_q == AW'(MAX_COLUMNS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (in_op == OP_READ) begin
						ram_en   = in_col_ok;
						ram_addr = AW'(in_col);
						state_d  = ST_FINISH;
					end else if (in_cam == cam_sel_q) begin
						state_d = in_raw ? ST_SCAN : ST_FINISH;
					end
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_FINISH;
				end else if (sh_q[FIELD_W-1]) begin
					ram_en  = 1'b1;
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				ram_en  = 1'b1;
				ram_we  = 1'b1;
				state_d = ST_SCAN;
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign new_pos   = pos_q + seg_len_q;
	assign line_len  = (new_pos == '0) ? POS_W'(1) : new_pos;
	assign col_start = (pos_q > POS_W'(12'hFFF)) ? 12'hFFF : pos_q[FIELD_W-1:0];
	assign count_val = in_range_q ? ram_rdata : '0;

	always_comb begin
		res_data = '0;
		if (op_q == OP_READ) begin
			res_data[96:65] = count_val;
		end else begin
			res_data[11:0]  = col_start;
			res_data[24:12] = seg_len_q;
			res_data[36:25] = seg_mask_q;
			if (eol_q) begin
				res_data[49:37] = line_len;
				res_data[62:50] = rowcnt_q;
				res_data[63]    = flow_q;
				res_data[64]    = ovf_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_sel_q  <= '0;
			cap_q      <= POS_W'(4096);
			pos_q      <= '0;
			rowcnt_q   <= '0;
			ovf_q      <= 1'b0;
			clr_addr_q <= '0;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_CAMERA) begin
					cam_sel_q <= cfg_data[1:0];
				end else begin
					cap_q <= cfg_data;
				end
			end
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (take_rec && !in_raw && blank_ovf) begin
				ovf_q <= 1'b1;
			end
			if (accept) begin
				idx_q <= '0;
			end else if (step) begin
				idx_q <= idx_q + 4'd1;
			end
			if (state_q == ST_WRITE) begin
				rowcnt_q <= rowcnt_q + POS_W'(1);
			end
			if (finish_go) begin
				m_tvalid_q <= 1'b1;
				if (op_q == OP_DECODE) begin
					if (eol_q) begin
						pos_q    <= '0;
						rowcnt_q <= '0;
						ovf_q    <= 1'b0;
					end else begin
						pos_q <= new_pos;
					end
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= in_op;
			eol_q       <= in_eol;
			flow_q      <= in_flow;
			in_range_q  <= in_col_ok;
			seg_len_q   <= seg_len_d;
			seg_mask_q  <= in_raw ? raw_mask : '0;
			seg_blank_q <= !in_raw;
			sh_q        <= raw_mask;
		end else if (step) begin
			sh_q <= sh_q << 1;
		end
		if (finish_go) begin
			m_tdata_q <= res_data;
			m_tuser_q <= (op_q == OP_DECODE) && seg_blank_q;
			m_tlast_q <= (op_q == OP_DECODE) && eol_q;
		end
	end

	bsrd_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(MAX_COLUMNS)
	) u_count_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;
	assign m_tlast   = m_tlast_q;

	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> $past(state_q == ST_SCAN))
		else $error("counter write without a preceding read");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ({9'd0, idx_q} <= seg_len_q))
		else $error("pixel index ran past the segment length");

	a_line_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tlast_q) |-> (m_tdata_q[49:37] != '0))
		else $error("closed line reported with zero length");

	a_drop_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_op == OP_DECODE) && (in_cam != cam_sel_q)) |=> (state_q == ST_IDLE))
		else $error("dropped record left the idle state");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == ST_CLEAR) && (state_q == ST_CLEAR) |-> !$past(accept))
		else $error("item taken during the clearing pass");

endmodule
